[hw/rtl/lcd4_pkg.sv]
// Shared types, constants and helpers for the 4-bit character-LCD controller.
// No dependencies; lcd4_exec, the top level and the result checker import it.
`default_nettype none

package lcd4_pkg;

    // Default geometry, handed down from the top level.
    localparam int unsigned DEF_DISPLAY_DEPTH = 80;
    localparam int unsigned DEF_GLYPH_DEPTH   = 64;
    localparam int unsigned DEF_SHIFT_SPAN    = 24;

    // Fill byte that every display entry reads back as after the clear command.
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Error codes reported with each result.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_INIT  = 2'd1;
    localparam logic [1:0] ERR_EIGHT = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    // Number of function-set commands that make up the init sequence.
    localparam logic [1:0] INIT_DONE = 2'd3;

    // Bit positions inside the mode flags.
    localparam int unsigned MF_INC   = 0;
    localparam int unsigned MF_SHIFT = 1;
    localparam int unsigned MF_DISP  = 2;
    localparam int unsigned MF_CURS  = 3;
    localparam int unsigned MF_BLINK = 4;
    localparam int unsigned MF_TWO   = 5;
    localparam int unsigned MF_SMALL = 6;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_HOME,
        CMD_ENTRY,
        CMD_ONOFF,
        CMD_SHIFT,
        CMD_FUNC,
        CMD_CGADDR,
        CMD_DDADDR
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_fsm;

    // Architectural registers that the command executor updates.
    typedef struct packed {
        logic [6:0] ddram;
        logic [5:0] cgram;
        logic       target;
        logic [6:0] cursor;
        logic [4:0] shift;
        logic [1:0] init_cnt;
        logic       nibble_mode;
        logic [6:0] flags;
    } t_ctl_state;

    // Side effects of one executed command.
    typedef struct packed {
        logic [1:0] err;
        logic       addr_ok;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       dd_wr;
        logic       cg_wr;
        logic       dd_clr;
    } t_exec_res;

    // Step a counter up or down, wrapping inside [0, depth).
    function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic up,
                                             input logic [7:0] depth);
        logic [7:0] r;
        if (up) begin
            r = ((v + 8'd1) >= depth) ? 8'd0 : (v + 8'd1);
        end else begin
            r = ((v == 8'd0) || (v >= depth)) ? (depth - 8'd1) : (v - 8'd1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lcd4_ram.sv]
// Byte-wide character memory with registered read and per-entry valid bits.
// Entries never written since reset or the last clear read back as the fill byte.
`default_nettype none

module lcd4_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_clr,
    input  wire logic [7:0]    i_clr_fill,
    output logic      [7:0]    o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_fill;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_fill <= 8'h00;
        end else if (i_clr) begin
            r_vld  <= '0;
            r_fill <= i_clr_fill;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_fill;

endmodule

`default_nettype wire

[hw/rtl/lcd4_exec.sv]
// Command decoder and executor: computes next counters, flags and RAM side effects.
// Purely combinational; uses lcd4_pkg for state and result types.
`default_nettype none

module lcd4_exec
    import lcd4_pkg::*;
#(
    parameter int unsigned DISPLAY_DEPTH = DEF_DISPLAY_DEPTH,
    parameter int unsigned GLYPH_DEPTH   = DEF_GLYPH_DEPTH,
    parameter int unsigned SHIFT_SPAN    = DEF_SHIFT_SPAN
) (
    input  wire t_ctl_state   i_state,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_rs,
    input  wire logic         i_rw,
    input  wire logic         i_run,
    input  wire logic [7:0]   i_rd_data,
    output t_ctl_state        o_state,
    output t_exec_res         o_res
);

    localparam logic [7:0] DD_LIM = 8'(DISPLAY_DEPTH);
    localparam logic [7:0] CG_LIM = 8'(GLYPH_DEPTH);
    localparam logic [7:0] SH_LIM = 8'(SHIFT_SPAN);

    t_cmd w_cmd;
    logic w_addr_ok;
    logic w_inc;
    logic w_right;

    always_comb begin
        if (i_byte[7])      w_cmd = CMD_DDADDR;
        else if (i_byte[6]) w_cmd = CMD_CGADDR;
        else if (i_byte[5]) w_cmd = CMD_FUNC;
        else if (i_byte[4]) w_cmd = CMD_SHIFT;
        else if (i_byte[3]) w_cmd = CMD_ONOFF;
        else if (i_byte[2]) w_cmd = CMD_ENTRY;
        else if (i_byte[1]) w_cmd = CMD_HOME;
        else if (i_byte[0]) w_cmd = CMD_CLEAR;
        else                w_cmd = CMD_NONE;
    end

    assign w_addr_ok = i_state.target ? ({2'b00, i_state.cgram} < CG_LIM)
                                      : ({1'b0, i_state.ddram} < DD_LIM);
    assign w_inc   = i_state.flags[MF_INC];
    assign w_right = i_byte[2];

    always_comb begin
        o_state         = i_state;
        o_res.err       = ERR_OK;
        o_res.addr_ok   = w_addr_ok;
        o_res.rd_valid  = 1'b0;
        o_res.rd_byte   = 8'h00;
        o_res.dd_wr     = 1'b0;
        o_res.cg_wr     = 1'b0;
        o_res.dd_clr    = 1'b0;

        if (i_run) begin
            if ((i_state.init_cnt != INIT_DONE) && (i_rs || i_rw || (w_cmd != CMD_FUNC))) begin
                o_res.err = ERR_INIT;
            end else if (i_rs) begin
                if (!w_addr_ok) begin
                    o_res.err = ERR_RANGE;
                end else begin
                    if (i_rw) begin
                        o_res.rd_valid = 1'b1;
                        o_res.rd_byte  = i_rd_data;
                    end else begin
                        o_res.dd_wr = !i_state.target;
                        o_res.cg_wr = i_state.target;
                    end
                    // advance counters after the data access
                    if (i_state.flags[MF_SHIFT]) begin
                        o_state.shift = 5'(wrap_step({3'b000, i_state.shift}, w_inc, SH_LIM));
                    end
                    if (i_state.target) begin
                        o_state.cgram = 6'(wrap_step({2'b00, i_state.cgram}, 1'b1, CG_LIM));
                    end else begin
                        o_state.ddram = 7'(wrap_step({1'b0, i_state.ddram}, 1'b1, DD_LIM));
                    end
                    if (i_state.flags[MF_CURS]) begin
                        o_state.cursor = 7'(wrap_step({1'b0, i_state.cursor}, w_inc, DD_LIM));
                    end
                end
            end else if (i_rw) begin
                // busy flag always reads as zero
                o_res.rd_valid = 1'b1;
                o_res.rd_byte  = {1'b0, i_state.ddram};
            end else begin
                case (w_cmd)
                    CMD_CLEAR: begin
                        o_res.dd_clr   = 1'b1;
                        o_state.ddram  = 7'd0;
                        o_state.target = 1'b0;
                        o_state.cursor = 7'd0;
                        o_state.shift  = 5'd0;
                    end
                    CMD_HOME: begin
                        o_state.ddram  = 7'd0;
                        o_state.target = 1'b0;
                        o_state.cursor = 7'd0;
                        o_state.shift  = 5'd0;
                    end
                    CMD_ENTRY: begin
                        o_state.flags[MF_INC]   = i_byte[1];
                        o_state.flags[MF_SHIFT] = i_byte[0];
                    end
                    CMD_ONOFF: begin
                        o_state.flags[MF_DISP]  = i_byte[2];
                        o_state.flags[MF_CURS]  = i_byte[1];
                        o_state.flags[MF_BLINK] = i_byte[0];
                    end
                    CMD_SHIFT: begin
                        if (i_byte[3]) begin
                            o_state.shift = 5'(wrap_step({3'b000, i_state.shift}, w_right,
                                                         SH_LIM));
                        end
                        o_state.cursor = 7'(wrap_step({1'b0, i_state.cursor}, w_right, DD_LIM));
                    end
                    CMD_FUNC: begin
                        if (i_state.init_cnt != INIT_DONE) begin
                            o_state.init_cnt = i_state.init_cnt + 2'd1;
                        end else if (i_byte[4]) begin
                            o_res.err = ERR_EIGHT;
                        end else begin
                            o_state.nibble_mode     = 1'b1;
                            o_state.flags[MF_TWO]   = i_byte[3];
                            o_state.flags[MF_SMALL] = !i_byte[2] || i_byte[3];
                        end
                    end
                    CMD_CGADDR: begin
                        o_state.cgram  = i_byte[5:0];
                        o_state.target = 1'b1;
                    end
                    CMD_DDADDR: begin
                        o_state.ddram  = i_byte[6:0];
                        o_state.target = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/char_lcd_controller_4bit.sv]
// Top level of the 4-bit character-LCD controller: strobe intake, nibble pairing,
// read-back sequencing and result register. Uses lcd4_pkg, lcd4_exec and lcd4_ram.
`default_nettype none

// Each request is one enable strobe of an HD44780-style bus (nibble, RS, RW) and
// gives exactly one result: the nibble driven back (if any), an error code and a
// snapshot of the counters and mode flags after the strobe. When a request is
// accepted the display or glyph RAM is read at the current address counter;
// then the command executes, the RAM is written back and the result register
// loads. A result still held by a stalled consumer delays execution until it
// is taken. The input side stalls while a request is executing. The clear
// command does not stall the block: per-entry valid bits in the display RAM
// are dropped at once and unwritten entries read back as a space. Before the
// third function-set the block only counts them and refuses other commands
// with error 1; after it, a function-set with bit 4 clear makes the bus pair
// high then low nibbles. Reads answer the high nibble at once and the low
// nibble on the next strobe.
module char_lcd_controller_4bit
    import lcd4_pkg::*;
#(
    parameter int unsigned DISPLAY_DEPTH = DEF_DISPLAY_DEPTH,
    parameter int unsigned GLYPH_DEPTH   = DEF_GLYPH_DEPTH,
    parameter int unsigned SHIFT_SPAN    = DEF_SHIFT_SPAN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // strobe channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [3:0] i_data_nibble,
    input  wire logic       i_reg_select,
    input  wire logic       i_read_not_write,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_drive_valid,
    output logic      [3:0] o_drive_nibble,
    output logic      [1:0] o_error_code,
    output logic      [6:0] o_ddram_address,
    output logic      [6:0] o_cursor_position,
    output logic      [4:0] o_display_offset,
    output logic            o_display_enabled,
    output logic            o_cursor_enabled,
    output logic            o_blink_enabled,
    output logic            o_two_line,
    output logic            o_small_font
);

    localparam int unsigned DD_AW = $clog2(DISPLAY_DEPTH);
    localparam int unsigned CG_AW = $clog2(GLYPH_DEPTH);

    // control registers
    t_fsm       r_fsm, n_fsm;
    t_ctl_state r_ctl;
    logic [3:0] r_high, n_high;
    logic [3:0] r_low, n_low;
    logic       r_phase, n_phase;
    logic       r_pend_vld, n_pend_vld;
    logic [3:0] r_pend_nib, n_pend_nib;
    logic       r_out_valid;

    // captured request
    logic [3:0] r_nib;
    logic       r_rs;
    logic       r_rw;

    // result payload
    logic       r_drive_valid, n_drive_valid;
    logic [3:0] r_drive_nibble, n_drive_nibble;
    logic [1:0] r_err;
    t_ctl_state r_snap;

    logic       w_accept;
    logic       w_done;
    logic       w_run;
    logic [7:0] w_rd_data;
    logic [7:0] w_dd_rd;
    logic [7:0] w_cg_rd;
    t_ctl_state w_next;
    t_exec_res  w_res;

    assign w_accept = i_in_valid && !o_in_stall;

    // Sequencer: issue the RAM read on accept in ST_IDLE, then execute in ST_EXEC
    // once the result register is free or being drained.
    always_comb begin
        n_fsm      = r_fsm;
        o_in_stall = 1'b1;
        w_done     = 1'b0;
        case (r_fsm)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_fsm = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_done = 1'b1;
                    n_fsm  = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ST_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Nibble pairing: in 4-bit mode a write runs on its low nibble, a read runs
    // on its high nibble. Before that every strobe is a full command that
    // reuses the last low half.
    always_comb begin
        n_high  = r_high;
        n_low   = r_low;
        n_phase = r_phase;
        w_run   = 1'b1;
        if (r_ctl.nibble_mode) begin
            if (r_phase) begin
                n_low = r_nib;
            end else begin
                n_high = r_nib;
            end
            n_phase = !r_phase;
            w_run   = (n_phase == r_rw);
        end else begin
            n_high = r_nib;
        end
    end

    assign w_rd_data = r_ctl.target ? w_cg_rd : w_dd_rd;

    lcd4_exec #(
        .DISPLAY_DEPTH (DISPLAY_DEPTH),
        .GLYPH_DEPTH   (GLYPH_DEPTH),
        .SHIFT_SPAN    (SHIFT_SPAN)
    ) u_exec (
        .i_state   (r_ctl),
        .i_byte    ({n_high, n_low}),
        .i_rs      (r_rs),
        .i_rw      (r_rw),
        .i_run     (w_run),
        .i_rd_data (w_rd_data),
        .o_state   (w_next),
        .o_res     (w_res)
    );

    // Read-back: a pending low nibble goes out on the very next strobe; a new
    // read on that strobe drives its own high nibble and drops the old one.
    always_comb begin
        n_drive_valid  = r_pend_vld;
        n_drive_nibble = r_pend_vld ? r_pend_nib : 4'h0;
        n_pend_vld     = 1'b0;
        n_pend_nib     = r_pend_nib;
        if (w_res.rd_valid) begin
            n_drive_valid  = 1'b1;
            n_drive_nibble = w_res.rd_byte[7:4];
            n_pend_vld     = 1'b1;
            n_pend_nib     = w_res.rd_byte[3:0];
        end
    end

    lcd4_ram #(
        .DEPTH (DISPLAY_DEPTH),
        .AW    (DD_AW)
    ) u_ddram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept && !r_ctl.target && w_res.addr_ok),
        .i_rd_addr  (r_ctl.ddram[DD_AW-1:0]),
        .i_wr_en    (w_done && w_res.dd_wr),
        .i_wr_addr  (r_ctl.ddram[DD_AW-1:0]),
        .i_wr_data  ({n_high, n_low}),
        .i_clr      (w_done && w_res.dd_clr),
        .i_clr_fill (SPACE_CHAR),
        .o_rd_data  (w_dd_rd)
    );

    lcd4_ram #(
        .DEPTH (GLYPH_DEPTH),
        .AW    (CG_AW)
    ) u_cgram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept && r_ctl.target && w_res.addr_ok),
        .i_rd_addr  (r_ctl.cgram[CG_AW-1:0]),
        .i_wr_en    (w_done && w_res.cg_wr),
        .i_wr_addr  (r_ctl.cgram[CG_AW-1:0]),
        .i_wr_data  ({n_high, n_low}),
        .i_clr      (1'b0),
        .i_clr_fill (8'h00),
        .o_rd_data  (w_cg_rd)
    );

    // Commit architectural state once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_high      <= 4'h0;
            r_low       <= 4'h0;
            r_phase     <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_pend_nib  <= 4'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_ctl       <= w_next;
                r_high      <= n_high;
                r_low       <= n_low;
                r_phase     <= n_phase;
                r_pend_vld  <= n_pend_vld;
                r_pend_nib  <= n_pend_nib;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nib <= i_data_nibble;
            r_rs  <= i_reg_select;
            r_rw  <= i_read_not_write;
        end
        if (w_done) begin
            r_drive_valid  <= n_drive_valid;
            r_drive_nibble <= n_drive_nibble;
            r_err          <= w_res.err;
            r_snap         <= w_next;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_valid     = r_drive_valid;
    assign o_drive_nibble    = r_drive_nibble;
    assign o_error_code      = r_err;
    assign o_ddram_address   = r_snap.ddram;
    assign o_cursor_position = r_snap.cursor;
    assign o_display_offset  = r_snap.shift;
    assign o_display_enabled = r_snap.flags[MF_DISP];
    assign o_cursor_enabled  = r_snap.flags[MF_CURS];
    assign o_blink_enabled   = r_snap.flags[MF_BLINK];
    assign o_two_line        = r_snap.flags[MF_TWO];
    assign o_small_font      = r_snap.flags[MF_SMALL];

endmodule

`default_nettype wire

[verif/lcd_result_checker.sv]
// Result checker for char_lcd_controller_4bit: watches both channels, predicts each result.
// Depends on lcd4_pkg for error codes, command enum and mode-flag positions.
`timescale 1ns / 1ps

module lcd_result_checker
    import lcd4_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [3:0] i_data_nibble,
    input  wire logic       i_reg_select,
    input  wire logic       i_read_not_write,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_drive_valid,
    input  wire logic [3:0] i_drive_nibble,
    input  wire logic [1:0] i_error_code,
    input  wire logic [6:0] i_ddram_address,
    input  wire logic [6:0] i_cursor_position,
    input  wire logic [4:0] i_display_offset,
    input  wire logic       i_display_enabled,
    input  wire logic       i_cursor_enabled,
    input  wire logic       i_blink_enabled,
    input  wire logic       i_two_line,
    input  wire logic       i_small_font,
    output int              o_fail_count,
    output int              o_outstanding
);

    localparam int unsigned DD_DEPTH = DEF_DISPLAY_DEPTH;
    localparam int unsigned CG_DEPTH = DEF_GLYPH_DEPTH;
    localparam int unsigned SPAN     = DEF_SHIFT_SPAN;

    typedef struct packed {
        logic       drive_valid;
        logic [3:0] drive_nibble;
        logic [1:0] error_code;
        logic [6:0] ddram_address;
        logic [6:0] cursor_position;
        logic [4:0] display_offset;
        logic       display_enabled;
        logic       cursor_enabled;
        logic       blink_enabled;
        logic       two_line;
        logic       small_font;
    } t_reply;

    // Mirror of the controller state.
    logic [7:0] dd_mem [DD_DEPTH];
    logic [7:0] cg_mem [CG_DEPTH];
    logic [6:0] dd_ptr;
    logic [5:0] cg_ptr;
    logic       to_glyph;
    logic [6:0] cur_pos;
    logic [4:0] scroll;
    logic [1:0] fs_seen;
    logic       four_bit;
    logic [6:0] flags;
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
    logic       odd_phase;
    logic       held_valid;
    logic [3:0] held_nib;

    t_reply pending_replies[$];
    int     mismatches;
    int     replies_seen;

    assign o_fail_count = mismatches;

    function automatic int unsigned roll(input int unsigned v, input logic up,
                                         input int unsigned span);
        if (up) begin
            return (v + 1 < span) ? v + 1 : 0;
        end
        if (v == 0 || v >= span) begin
            return span - 1;
        end
        return v - 1;
    endfunction

    function automatic void clear_model();
        foreach (dd_mem[i]) dd_mem[i] = '0;
        foreach (cg_mem[i]) cg_mem[i] = '0;
        dd_ptr     = '0;
        cg_ptr     = '0;
        to_glyph   = 1'b0;
        cur_pos    = '0;
        scroll     = '0;
        fs_seen    = '0;
        four_bit   = 1'b0;
        flags      = '0;
        hi_nib     = '0;
        lo_nib     = '0;
        odd_phase  = 1'b0;
        held_valid = 1'b0;
        held_nib   = '0;
    endfunction

    function automatic t_cmd decode_cmd(input logic [7:0] b);
        casez (b)
            8'b1???_????: return CMD_DDADDR;
            8'b01??_????: return CMD_CGADDR;
            8'b001?_????: return CMD_FUNC;
            8'b0001_????: return CMD_SHIFT;
            8'b0000_1???: return CMD_ONOFF;
            8'b0000_01??: return CMD_ENTRY;
            8'b0000_001?: return CMD_HOME;
            8'b0000_0001: return CMD_CLEAR;
            default:      return CMD_NONE;
        endcase
    endfunction

    // Advance the counters after a data access.
    function automatic void step_after_access();
        logic up;
        up = flags[MF_INC];
        if (flags[MF_SHIFT]) scroll = 5'(roll(scroll, up, SPAN));
        if (to_glyph) begin
            cg_ptr = 6'(roll(cg_ptr, 1'b1, CG_DEPTH));
        end else begin
            dd_ptr = 7'(roll(dd_ptr, 1'b1, DD_DEPTH));
        end
        if (flags[MF_CURS]) cur_pos = 7'(roll(cur_pos, up, DD_DEPTH));
    endfunction

    function automatic logic [1:0] run_command(input logic [7:0] b, input logic rs,
                                               input logic rw, output logic rd_ok,
                                               output logic [7:0] rd_byte);
        t_cmd cmd;
        logic in_range;
        cmd     = decode_cmd(b);
        rd_ok   = 1'b0;
        rd_byte = '0;
        if (fs_seen < INIT_DONE && (rs || rw || cmd != CMD_FUNC)) return ERR_INIT;
        in_range = to_glyph ? (cg_ptr < CG_DEPTH) : (dd_ptr < DD_DEPTH);
        if (rs) begin
            if (!in_range) return ERR_RANGE;
            if (rw) begin
                rd_ok   = 1'b1;
                rd_byte = to_glyph ? cg_mem[cg_ptr] : dd_mem[dd_ptr];
            end else if (to_glyph) begin
                cg_mem[cg_ptr] = b;
            end else begin
                dd_mem[dd_ptr] = b;
            end
            step_after_access();
            return ERR_OK;
        end
        if (rw) begin
            // busy flag always reads as zero
            rd_ok   = 1'b1;
            rd_byte = {1'b0, dd_ptr};
            return ERR_OK;
        end
        case (cmd)
            CMD_CLEAR, CMD_HOME: begin
                if (cmd == CMD_CLEAR) begin
                    foreach (dd_mem[i]) dd_mem[i] = SPACE_CHAR;
                end
                dd_ptr   = '0;
                to_glyph = 1'b0;
                cur_pos  = '0;
                scroll   = '0;
            end
            CMD_ENTRY: begin
                flags[MF_INC]   = b[1];
                flags[MF_SHIFT] = b[0];
            end
            CMD_ONOFF: begin
                flags[MF_DISP]  = b[2];
                flags[MF_CURS]  = b[1];
                flags[MF_BLINK] = b[0];
            end
            CMD_SHIFT: begin
                if (b[3]) scroll = 5'(roll(scroll, b[2], SPAN));
                cur_pos = 7'(roll(cur_pos, b[2], DD_DEPTH));
            end
            CMD_FUNC: begin
                if (fs_seen < INIT_DONE) begin
                    fs_seen = fs_seen + 2'd1;
                end else if (b[4]) begin
                    return ERR_EIGHT;
                end else begin
                    four_bit        = 1'b1;
                    flags[MF_TWO]   = b[3];
                    flags[MF_SMALL] = !b[2] || b[3];
                end
            end
            CMD_CGADDR: begin
                cg_ptr   = b[5:0];
                to_glyph = 1'b1;
            end
            CMD_DDADDR: begin
                dd_ptr   = b[6:0];
                to_glyph = 1'b0;
            end
            default: ;
        endcase
        return ERR_OK;
    endfunction

    // Predict the result of one accepted strobe and update the mirror.
    function automatic t_reply predict_strobe(input logic [3:0] nib, input logic rs,
                                              input logic rw);
        t_reply     r;
        logic       exec;
        logic       rd_ok;
        logic [7:0] rd_byte;
        logic [1:0] err;
        r       = '0;
        err     = ERR_OK;
        exec    = 1'b1;
        rd_ok   = 1'b0;
        rd_byte = '0;
        // a held low nibble goes out on the very next strobe
        if (held_valid) begin
            r.drive_valid  = 1'b1;
            r.drive_nibble = held_nib;
            held_valid     = 1'b0;
        end
        if (four_bit) begin
            if (odd_phase) lo_nib = nib;
            else hi_nib = nib;
            odd_phase = !odd_phase;
            // writes run on the low half, reads on the high half
            exec = odd_phase ? rw : !rw;
        end else begin
            hi_nib = nib;
        end
        if (exec) begin
            err = run_command({hi_nib, lo_nib}, rs, rw, rd_ok, rd_byte);
            if (rd_ok) begin
                r.drive_valid  = 1'b1;
                r.drive_nibble = rd_byte[7:4];
                held_valid     = 1'b1;
                held_nib       = rd_byte[3:0];
            end
        end
        r.error_code      = err;
        r.ddram_address   = dd_ptr;
        r.cursor_position = cur_pos;
        r.display_offset  = scroll;
        r.display_enabled = flags[MF_DISP];
        r.cursor_enabled  = flags[MF_CURS];
        r.blink_enabled   = flags[MF_BLINK];
        r.two_line        = flags[MF_TWO];
        r.small_font      = flags[MF_SMALL];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            clear_model();
            pending_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_drive_valid, i_drive_nibble, i_error_code, i_ddram_address,
                       i_cursor_position, i_display_offset, i_display_enabled,
                       i_cursor_enabled, i_blink_enabled, i_two_line, i_small_font};
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: arrived with no request outstanding", replies_seen);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: exp dv=%b dn=%h err=%0d dd=%0d cur=%0d off=%0d fl=%b",
                                     replies_seen, want.drive_valid, want.drive_nibble,
                                     want.error_code, want.ddram_address,
                                     want.cursor_position, want.display_offset,
                                     {want.display_enabled, want.cursor_enabled,
                                      want.blink_enabled, want.two_line, want.small_font});
                            $display("result %0d: got dv=%b dn=%h err=%0d dd=%0d cur=%0d off=%0d fl=%b",
                                     replies_seen, got.drive_valid, got.drive_nibble,
                                     got.error_code, got.ddram_address,
                                     got.cursor_position, got.display_offset,
                                     {got.display_enabled, got.cursor_enabled,
                                      got.blink_enabled, got.two_line, got.small_font});
                        end
                    end
                end
                replies_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.push_back(predict_strobe(i_data_nibble, i_reg_select,
                                                         i_read_not_write));
            end
        end
        o_outstanding <= pending_replies.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for char_lcd_controller_4bit: clock, reset, strobe stimulus and verdict.
// Depends on the controller RTL, lcd4_pkg and lcd_result_checker.
`timescale 1ns / 1ps

module tb_top;

    // Instruction byte bases; the set bit picks the command.
    localparam logic [7:0] OPC_NONE   = 8'h00;
    localparam logic [7:0] OPC_CLEAR  = 8'h01;
    localparam logic [7:0] OPC_HOME   = 8'h02;
    localparam logic [7:0] OPC_ENTRY  = 8'h04;
    localparam logic [7:0] OPC_ONOFF  = 8'h08;
    localparam logic [7:0] OPC_SHIFT  = 8'h10;
    localparam logic [7:0] OPC_FUNC   = 8'h20;
    localparam logic [7:0] OPC_CGADDR = 8'h40;
    localparam logic [7:0] OPC_DDADDR = 8'h80;

    localparam int STROBE_TOTAL    = 1280;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;

    logic       i_clk          = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [3:0] data_nibble    = 4'h0;
    logic       reg_select     = 1'b0;
    logic       read_not_write = 1'b0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic       drive_valid;
    logic [3:0] drive_nibble;
    logic [1:0] error_code;
    logic [6:0] ddram_address;
    logic [6:0] cursor_position;
    logic [4:0] display_offset;
    logic       display_enabled;
    logic       cursor_enabled;
    logic       blink_enabled;
    logic       two_line;
    logic       small_font;

    int fail_count;
    int outstanding;
    int cycles         = 0;
    int strobes_sent   = 0;
    int holdoffs_asked = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;
    bit four_bit_on    = 1'b0;
    bit phase_odd      = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    char_lcd_controller_4bit dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_nibble    (data_nibble),
        .i_reg_select     (reg_select),
        .i_read_not_write (read_not_write),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_drive_valid    (drive_valid),
        .o_drive_nibble   (drive_nibble),
        .o_error_code     (error_code),
        .o_ddram_address  (ddram_address),
        .o_cursor_position(cursor_position),
        .o_display_offset (display_offset),
        .o_display_enabled(display_enabled),
        .o_cursor_enabled (cursor_enabled),
        .o_blink_enabled  (blink_enabled),
        .o_two_line       (two_line),
        .o_small_font     (small_font)
    );

    lcd_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_data_nibble    (data_nibble),
        .i_reg_select     (reg_select),
        .i_read_not_write (read_not_write),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_drive_valid    (drive_valid),
        .i_drive_nibble   (drive_nibble),
        .i_error_code     (error_code),
        .i_ddram_address  (ddram_address),
        .i_cursor_position(cursor_position),
        .i_display_offset (display_offset),
        .i_display_enabled(display_enabled),
        .i_cursor_enabled (cursor_enabled),
        .i_blink_enabled  (blink_enabled),
        .i_two_line       (two_line),
        .i_small_font     (small_font),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: stall at random, or hold off for a long stretch when asked so
    // that the result register stays full and the block stalls its input.
    initial begin : result_sink
        int hold_left;
        int holdoffs_done;
        hold_left     = 0;
        holdoffs_done = 0;
        forever begin
            @(posedge i_clk);
            if (holdoffs_asked != holdoffs_done) begin
                holdoffs_done = holdoffs_asked;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !rx_calm && ($urandom_range(99) < 14);
            end
        end
    end

    // Offer one strobe request and hold it until the block takes it.
    task automatic send_strobe(input logic [3:0] nib, input logic sel, input logic rd);
        while (!tx_calm && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        data_nibble    <= nib;
        reg_select     <= sel;
        read_not_write <= rd;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        strobes_sent++;
        // in 4-bit mode every strobe flips the pairing phase
        if (four_bit_on) phase_odd = !phase_odd;
    endtask

    // Write a whole byte on the 4-bit bus: high nibble, then low.
    task automatic send_byte(input logic [7:0] b, input logic sel);
        send_strobe(b[7:4], sel, 1'b0);
        send_strobe(b[3:0], sel, 1'b0);
    endtask

    // Read on the 4-bit bus: the first strobe executes, the second takes the low half.
    task automatic send_read(input logic sel);
        send_strobe(4'($urandom_range(15)), sel, 1'b1);
        send_strobe(4'($urandom_range(15)), sel, 1'b1);
    endtask

    // Hold until every predicted result has come back.
    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_instruction();
        int r;
        r = $urandom_range(99);
        if (r < 3) return OPC_CLEAR;
        if (r < 8) return OPC_HOME | 8'($urandom_range(1));
        if (r < 18) return OPC_ENTRY | 8'($urandom_range(3));
        if (r < 28) return OPC_ONOFF | 8'($urandom_range(7));
        if (r < 45) return OPC_SHIFT | 8'($urandom_range(15));
        if (r < 52) return OPC_FUNC | 8'($urandom_range(31));
        if (r < 62) return OPC_CGADDR | 8'($urandom_range(63));
        if (r < 95) begin
            // mostly inside the display RAM, sometimes past its end
            if ($urandom_range(99) < 15) return OPC_DDADDR | 8'($urandom_range(127, 80));
            return OPC_DDADDR | 8'($urandom_range(79));
        end
        return OPC_NONE;
    endfunction

    initial begin : stimulus
        int  k;
        bit  holdoff_done;
        bit  pause_done;
        holdoff_done = 1'b0;
        pause_done   = 1'b0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Before init: refuse everything but function set.
        send_strobe(4'h0, 1'b0, 1'b0);   // empty instruction
        send_strobe(4'h8, 1'b1, 1'b0);   // data write
        send_strobe(4'h4, 1'b0, 1'b1);   // busy/address read
        send_strobe(4'h3, 1'b0, 1'b0);
        send_strobe(4'h2, 1'b0, 1'b0);
        send_strobe(4'h3, 1'b0, 1'b0);
        // Initialized, still on the 8-bit bus.
        send_strobe(4'h3, 1'b0, 1'b0);   // eight-bit function set refused
        send_strobe(4'h0, 1'b0, 1'b0);   // empty instruction does nothing
        send_strobe(4'hF, 1'b1, 1'b1);   // data read, low half comes on next strobe
        send_strobe(4'h2, 1'b0, 1'b0);   // switch to the 4-bit bus
        four_bit_on = 1'b1;
        phase_odd   = 1'b0;

        // 4-bit bus: one pass over every command but return-home, and the corner cases.
        send_byte(OPC_FUNC | 8'h08, 1'b0);     // two lines
        send_byte(OPC_FUNC | 8'h1C, 1'b0);     // eight-bit refused
        send_byte(OPC_ENTRY | 8'h03, 1'b0);    // increment with shift
        send_byte(OPC_ONOFF | 8'h07, 1'b0);
        send_byte(OPC_DDADDR | 8'h7F, 1'b0);   // past the display RAM
        send_byte(8'hFF, 1'b1);                // out-of-range write
        send_byte(OPC_CLEAR, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_read(1'b1);                       // reads a cleared entry
        send_byte(OPC_CGADDR | 8'h3F, 1'b0);   // last glyph entry
        send_read(1'b0);
        send_byte(OPC_SHIFT | 8'h08, 1'b0);    // shift display and cursor left

        while (strobes_sent < STROBE_TOTAL) begin
            // long result hold-off while requests keep coming
            if (!holdoff_done && strobes_sent >= 300) begin
                holdoffs_asked++;
                holdoff_done = 1'b1;
            end
            tx_calm = (strobes_sent >= 500 && strobes_sent < 750);
            rx_calm = tx_calm;
            // stop offering until the block has answered everything
            if (!pause_done && strobes_sent >= 900) begin
                in_valid <= 1'b0;
                wait_drained();
                pause_done = 1'b1;
            end

            k = $urandom_range(99);
            if (k < 8) begin
                // stray strobe: breaks the nibble pairing
                send_strobe(4'($urandom_range(15)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
            end else begin
                // realign the pairing most of the time
                if (phase_odd && $urandom_range(9) < 8) begin
                    send_strobe(4'($urandom_range(15)), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
                end
                if (k < 40) send_byte(pick_instruction(), 1'b0);
                else if (k < 70) send_byte(8'($urandom_range(255)), 1'b1);
                else if (k < 90) send_read(1'b1);
                else send_read(1'b0);
            end
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
